FILE: rtl/core/mastep_pkg.sv
// ----------------------------------------------------------------------------
// mastep_pkg: shared types and constants of the stepper pulse controller
// Opcodes, field widths, the decoded command and the result beat layout.
// ----------------------------------------------------------------------------
package mastep_pkg;

	localparam int MAX_AXES     = 3;
	localparam int NUM_AXES_DEF = 3;
	localparam int OP_W         = 4;
	localparam int AXIS_W       = 2;
	localparam int STEP_W       = 31;
	localparam int POS_W        = 32;
	localparam int PERIOD_W     = 16;
	localparam int CFG_IDX_W    = 2;
	localparam int QUEUE_DEPTH  = 2;

	localparam logic [STEP_W-1:0]   STEP_MAX     = {STEP_W{1'b1}};
	localparam logic [PERIOD_W-1:0] PERIOD_RESET = 16'd100;

	localparam logic [OP_W-1:0] OP_TICK        = 4'd0;
	localparam logic [OP_W-1:0] OP_ENABLE      = 4'd1;
	localparam logic [OP_W-1:0] OP_DISABLE     = 4'd2;
	localparam logic [OP_W-1:0] OP_STOP        = 4'd3;
	localparam logic [OP_W-1:0] OP_MOVE_REL    = 4'd4;
	localparam logic [OP_W-1:0] OP_MOVE_ABS    = 4'd5;
	localparam logic [OP_W-1:0] OP_HOME        = 4'd6;
	localparam logic [OP_W-1:0] OP_START_LIMIT = 4'd7;
	localparam logic [OP_W-1:0] OP_END_LIMIT   = 4'd8;

	typedef enum logic [3:0] {
		K_NOP,
		K_TICK,
		K_ENABLE,
		K_DISABLE,
		K_STOP,
		K_MOVE_REL,
		K_MOVE_ABS,
		K_HOME,
		K_LIM_START,
		K_LIM_END
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t           kind;
		logic                ax_ok;
		logic [AXIS_W-1:0]   axis;
		logic [STEP_W-1:0]   step_count;
		logic                direction;
		logic [POS_W-1:0]    target;
	} cmd_t;

	typedef struct packed {
		logic [MAX_AXES-1:0] step_pins;
		logic [MAX_AXES-1:0] dir_pins;
		logic [MAX_AXES-1:0] enable_pins_n;
		logic                rejected;
		logic                homing_done;
		logic [POS_W-1:0]    position;
		logic [STEP_W-1:0]   steps_remaining;
		logic [STEP_W-1:0]   travel_length;
	} res_t;

	localparam int CMD_W = $bits(cmd_t);
	localparam int RES_W = $bits(res_t);

endpackage

FILE: rtl/core/mastep_fifo.sv
// ----------------------------------------------------------------------------
// mastep_fifo: small synchronous queue
// Register based first-in first-out store with full and empty flags.
// ----------------------------------------------------------------------------
module mastep_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wdata,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] rdata,
	output logic             empty
);

	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push;
	logic             do_pop;

	assign full    = (count_q == CNT_W'(DEPTH));
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			unique case ({do_push, do_pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

FILE: rtl/core/mastep_front.sv
// ----------------------------------------------------------------------------
// mastep_front: command intake and classification
// Decodes each accepted beat into a command kind and queues it for the back end.
// ----------------------------------------------------------------------------
module mastep_front import mastep_pkg::*; #(
	parameter int NUM_AXES = NUM_AXES_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	output logic                full,
	input  logic [OP_W-1:0]     op,
	input  logic [AXIS_W-1:0]   axis,
	input  logic [STEP_W-1:0]   step_count,
	input  logic                direction,
	input  logic [POS_W-1:0]    target,
	input  logic                cmd_pop,
	output logic                cmd_valid,
	output cmd_t                cmd
);

	cmd_t             dec;
	logic             ax_ok;
	logic [CMD_W-1:0] cmd_bits;
	logic             cmd_empty;

	assign ax_ok = (int'(axis) < NUM_AXES);

	// Per-axis commands aimed at a missing axis turn into no-ops here.
	always_comb begin
		dec.ax_ok      = ax_ok;
		dec.axis       = axis;
		dec.step_count = step_count;
		dec.direction  = direction;
		dec.target     = target;
		unique case (op)
			OP_TICK:        dec.kind = K_TICK;
			OP_ENABLE:      dec.kind = K_ENABLE;
			OP_DISABLE:     dec.kind = K_DISABLE;
			OP_STOP:        dec.kind = K_STOP;
			OP_MOVE_REL:    dec.kind = ax_ok ? K_MOVE_REL : K_NOP;
			OP_MOVE_ABS:    dec.kind = ax_ok ? K_MOVE_ABS : K_NOP;
			OP_HOME:        dec.kind = K_HOME;
			OP_START_LIMIT: dec.kind = ax_ok ? K_LIM_START : K_NOP;
			OP_END_LIMIT:   dec.kind = ax_ok ? K_LIM_END : K_NOP;
			default:        dec.kind = K_NOP;
		endcase
	end

	mastep_fifo #(
		.WIDTH (CMD_W),
		.DEPTH (QUEUE_DEPTH)
	) u_cmd_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wdata  (dec),
		.full   (full),
		.pop    (cmd_pop),
		.rdata  (cmd_bits),
		.empty  (cmd_empty)
	);

	assign cmd       = cmd_t'(cmd_bits);
	assign cmd_valid = !cmd_empty;

endmodule

FILE: rtl/core/mastep_back.sv
// ----------------------------------------------------------------------------
// mastep_back: axis execution and result queue
// Applies one decoded command per cycle, while the result queue has room, to all axis lanes and queues the readout.
// ----------------------------------------------------------------------------
module mastep_back import mastep_pkg::*; #(
	parameter int NUM_AXES = NUM_AXES_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_valid,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [PERIOD_W-1:0]  cfg_data,
	input  logic                 cmd_valid,
	input  cmd_t                 cmd,
	output logic                 cmd_pop,
	input  logic                 res_pop,
	output res_t                 res,
	output logic                 res_empty
);

	logic [NUM_AXES-1:0][PERIOD_W-1:0] period_q;
	logic [NUM_AXES-1:0]               en_q, fwd_q, homing_q, step_lvl_q, dir_lvl_q, en_lvl_n_q;
	logic [NUM_AXES-1:0][STEP_W-1:0]   steps_q, travel_q;
	logic [NUM_AXES-1:0][PERIOD_W-1:0] cnt_q;
	logic [NUM_AXES-1:0][POS_W-1:0]    pos_q;

	logic [NUM_AXES-1:0]               en_d, fwd_d, homing_d, step_lvl_d, dir_lvl_d, en_lvl_n_d;
	logic [NUM_AXES-1:0][STEP_W-1:0]   steps_d, travel_d;
	logic [NUM_AXES-1:0][PERIOD_W-1:0] cnt_d;
	logic [NUM_AXES-1:0][POS_W-1:0]    pos_d;
	logic [NUM_AXES-1:0]               rej_lane;

	logic              fire;
	logic              res_full;
	logic [RES_W-1:0]  res_bits;
	res_t              res_d;

	logic [POS_W-1:0]  pos_sel;
	logic [POS_W:0]    d_tp, d_pt, mag;
	logic [STEP_W-1:0] abs_steps;
	logic              abs_fwd;

	assign fire    = cmd_valid && !res_full;
	assign cmd_pop = fire;

	// Distance to an absolute target, taken both ways round so that the
	// magnitude needs only a select rather than a negation after the subtract.
	always_comb begin
		pos_sel = '0;
		for (int i = 0; i < NUM_AXES; i++) begin
			if (cmd.axis == AXIS_W'(i)) begin
				pos_sel = pos_q[i];
			end
		end
		d_tp      = {cmd.target[POS_W-1], cmd.target} - {pos_sel[POS_W-1], pos_sel};
		d_pt      = {pos_sel[POS_W-1], pos_sel} - {cmd.target[POS_W-1], cmd.target};
		abs_fwd   = !d_tp[POS_W] && (d_tp != '0);
		mag       = d_tp[POS_W] ? d_pt : d_tp;
		abs_steps = mag[POS_W-1] ? STEP_MAX : mag[STEP_W-1:0];
	end

	for (genvar g = 0; g < NUM_AXES; g++) begin : g_lane
		logic                sel;
		logic                start;
		logic [STEP_W-1:0]   st_steps;
		logic                st_fwd;
		logic [PERIOD_W-1:0] cnt_inc;

		assign sel     = cmd.ax_ok && (cmd.axis == AXIS_W'(g));
		assign cnt_inc = cnt_q[g] + 1'b1;

		always_comb begin
			en_d[g]       = en_q[g];
			fwd_d[g]      = fwd_q[g];
			homing_d[g]   = homing_q[g];
			step_lvl_d[g] = step_lvl_q[g];
			dir_lvl_d[g]  = dir_lvl_q[g];
			en_lvl_n_d[g] = en_lvl_n_q[g];
			steps_d[g]    = steps_q[g];
			travel_d[g]   = travel_q[g];
			cnt_d[g]      = cnt_q[g];
			pos_d[g]      = pos_q[g];
			start         = 1'b0;
			st_steps      = STEP_MAX;
			st_fwd        = 1'b0;
			unique case (cmd.kind)
				K_TICK: begin
					if (en_q[g] && (steps_q[g] != '0)) begin
						step_lvl_d[g] = ({cnt_inc, 1'b0} <= {1'b0, period_q[g]});
						if (cnt_inc >= period_q[g]) begin
							cnt_d[g]   = '0;
							steps_d[g] = steps_q[g] - 1'b1;
							pos_d[g]   = fwd_q[g] ? pos_q[g] + 1'b1 : pos_q[g] - 1'b1;
						end else begin
							cnt_d[g] = cnt_inc;
						end
					end
				end
				K_ENABLE: begin
					en_d[g]       = 1'b1;
					en_lvl_n_d[g] = 1'b0;
					steps_d[g]    = '0;
					cnt_d[g]      = '0;
				end
				K_DISABLE: begin
					en_d[g]       = 1'b0;
					en_lvl_n_d[g] = 1'b1;
					steps_d[g]    = '0;
					cnt_d[g]      = '0;
				end
				K_STOP: begin
					steps_d[g] = '0;
				end
				K_MOVE_REL: begin
					start    = sel;
					st_steps = cmd.step_count;
					st_fwd   = cmd.direction;
				end
				K_MOVE_ABS: begin
					start    = sel;
					st_steps = abs_steps;
					st_fwd   = abs_fwd;
				end
				K_HOME: begin
					homing_d[g] = 1'b1;
					start       = 1'b1;
					st_fwd      = 1'b1;
				end
				K_LIM_START: begin
					if (sel && homing_q[g]) begin
						fwd_d[g] = 1'b0;
						start    = 1'b1;
					end
				end
				K_LIM_END: begin
					if (sel && homing_q[g]) begin
						travel_d[g] = ~steps_q[g];
						pos_d[g]    = '0;
						steps_d[g]  = '0;
						homing_d[g] = 1'b0;
					end
				end
				default: begin
				end
			endcase
			// A move only takes hold on an enabled axis.
			if (start && en_q[g]) begin
				steps_d[g]    = st_steps;
				fwd_d[g]      = st_fwd;
				dir_lvl_d[g]  = st_fwd;
				step_lvl_d[g] = 1'b1;
			end
			rej_lane[g] = start && !en_q[g];
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				period_q[g] <= PERIOD_RESET;
			end else if (cfg_valid && (cfg_index == CFG_IDX_W'(g))) begin
				period_q[g] <= cfg_data;
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				en_q[g]       <= 1'b0;
				fwd_q[g]      <= 1'b0;
				homing_q[g]   <= 1'b0;
				step_lvl_q[g] <= 1'b0;
				dir_lvl_q[g]  <= 1'b0;
				en_lvl_n_q[g] <= 1'b1;
				steps_q[g]    <= '0;
				travel_q[g]   <= '0;
				cnt_q[g]      <= '0;
				pos_q[g]      <= '0;
			end else if (fire) begin
				en_q[g]       <= en_d[g];
				fwd_q[g]      <= fwd_d[g];
				homing_q[g]   <= homing_d[g];
				step_lvl_q[g] <= step_lvl_d[g];
				dir_lvl_q[g]  <= dir_lvl_d[g];
				en_lvl_n_q[g] <= en_lvl_n_d[g];
				steps_q[g]    <= steps_d[g];
				travel_q[g]   <= travel_d[g];
				cnt_q[g]      <= cnt_d[g];
				pos_q[g]      <= pos_d[g];
			end
		end
	end

	// Readout is taken from the state after this command has been applied.
	always_comb begin
		res_d.step_pins       = '0;
		res_d.dir_pins        = '0;
		res_d.enable_pins_n   = '1;
		res_d.rejected        = |rej_lane;
		res_d.homing_done     = ~|homing_d;
		res_d.position        = '0;
		res_d.steps_remaining = '0;
		res_d.travel_length   = '0;
		for (int i = 0; i < NUM_AXES; i++) begin
			res_d.step_pins[i]     = step_lvl_d[i];
			res_d.dir_pins[i]      = dir_lvl_d[i];
			res_d.enable_pins_n[i] = en_lvl_n_d[i];
			if (cmd.ax_ok && (cmd.axis == AXIS_W'(i))) begin
				res_d.position        = pos_d[i];
				res_d.steps_remaining = steps_d[i];
				res_d.travel_length   = travel_d[i];
			end
		end
	end

	mastep_fifo #(
		.WIDTH (RES_W),
		.DEPTH (QUEUE_DEPTH)
	) u_res_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (fire),
		.wdata  (res_d),
		.full   (res_full),
		.pop    (res_pop),
		.rdata  (res_bits),
		.empty  (res_empty)
	);

	assign res = res_t'(res_bits);

endmodule

FILE: rtl/core/multi_axis_stepper_pulse_controller_unit.sv
// ----------------------------------------------------------------------------
// multi_axis_stepper_pulse_controller_unit: three-axis step and direction unit
// Command and tick driven step pulse generator with homing and readout.
// ----------------------------------------------------------------------------
// Usage. Commands and timer ticks arrive on a queue-style input: a beat is
// taken at a clock edge where push is high and full is low. Every beat
// produces exactly one result beat, presented on the result ports while empty
// is low and taken at an edge where pop is high. Results come out in order.
// A beat taken at one edge is decoded into the command queue, executed on
// all axis lanes once the result queue has room, and is visible as a result
// straight after it. Throughput is one beat per cycle while the receiver keeps
// popping; each lane updates its counters together with its other state, so a
// tick costs no more than any other command.
// If the receiver stops popping, the result queue fills, execution pauses,
// then the command queue fills and full rises; nothing is dropped. Two beats
// may be held in each queue.
// The period registers are written through the cfg channel, which is always
// ready; they should be changed only while no beats are in flight.
// Reset clears both queues, disables all drivers (enable_pins_n all high),
// zeroes every counter and position and sets each period to 100 ticks.
// ----------------------------------------------------------------------------
module multi_axis_stepper_pulse_controller_unit import mastep_pkg::*; #(
	parameter int NUM_AXES = NUM_AXES_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	// configuration write channel
	input  logic                      cfg_valid,
	output logic                      cfg_ready,
	input  logic [CFG_IDX_W-1:0]      cfg_index,
	input  logic [PERIOD_W-1:0]       cfg_data,
	// command input
	input  logic                      push,
	output logic                      full,
	input  logic [OP_W-1:0]           op,
	input  logic [AXIS_W-1:0]         axis,
	input  logic [STEP_W-1:0]         step_count,
	input  logic                      direction,
	input  logic signed [POS_W-1:0]   target,
	// result output
	output logic                      empty,
	input  logic                      pop,
	output logic [MAX_AXES-1:0]       step_pins,
	output logic [MAX_AXES-1:0]       dir_pins,
	output logic [MAX_AXES-1:0]       enable_pins_n,
	output logic                      rejected,
	output logic                      homing_done,
	output logic signed [POS_W-1:0]   position,
	output logic [STEP_W-1:0]         steps_remaining,
	output logic [STEP_W-1:0]         travel_length
);

	cmd_t cmd;
	logic cmd_valid;
	logic cmd_pop;
	res_t res;

	// The period registers take a write in any cycle.
	assign cfg_ready = 1'b1;

	mastep_front #(
		.NUM_AXES (NUM_AXES)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.full       (full),
		.op         (op),
		.axis       (axis),
		.step_count (step_count),
		.direction  (direction),
		.target     (target),
		.cmd_pop    (cmd_pop),
		.cmd_valid  (cmd_valid),
		.cmd        (cmd)
	);

	mastep_back #(
		.NUM_AXES (NUM_AXES)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cmd_valid (cmd_valid),
		.cmd       (cmd),
		.cmd_pop   (cmd_pop),
		.res_pop   (pop),
		.res       (res),
		.res_empty (empty)
	);

	// Unpack the head of the result queue onto the individual ports.
	assign step_pins       = res.step_pins;
	assign dir_pins        = res.dir_pins;
	assign enable_pins_n   = res.enable_pins_n;
	assign rejected        = res.rejected;
	assign homing_done     = res.homing_done;
	assign position        = res.position;
	assign steps_remaining = res.steps_remaining;
	assign travel_length   = res.travel_length;

endmodule

FILE: tb/sv/tb_multi_axis_stepper_pulse_controller_unit.sv
// ----------------------------------------------------------------------------
// tb_multi_axis_stepper_pulse_controller_unit: self-checking bench of the unit
// Commands and timer ticks are queued up, driven one beat at a time, and every
// result beat is checked against an in-bench prediction of the three axes,
// over several period settings and with random idling on both sides.
// ----------------------------------------------------------------------------
module tb_multi_axis_stepper_pulse_controller_unit import mastep_pkg::*; ();

	timeunit 1ns;
	timeprecision 1ps;

	localparam int AXES        = NUM_AXES_DEF;
	localparam int CYCLE_LIMIT = 300000;

	// Register indexes of the configuration channel.
	localparam logic [CFG_IDX_W-1:0] REG_PERIOD_AXIS0 = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_PERIOD_AXIS1 = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_PERIOD_AXIS2 = 2'd2;

	// One command beat as it appears on the input ports.
	typedef struct packed {
		logic [OP_W-1:0]   op;
		logic [AXIS_W-1:0] axis;
		logic [STEP_W-1:0] step_count;
		logic              direction;
		logic [POS_W-1:0]  target;
	} motion_cmd_t;

	// Every input is given a known value from time zero onwards.
	logic                   clk;
	logic                   arst_n     = 1'b0;
	logic                   cfg_valid  = 1'b0;
	logic                   cfg_ready;
	logic [CFG_IDX_W-1:0]   cfg_index  = '0;
	logic [PERIOD_W-1:0]    cfg_data   = '0;
	logic                   push       = 1'b0;
	logic                   full;
	logic [OP_W-1:0]        op         = '0;
	logic [AXIS_W-1:0]      axis       = '0;
	logic [STEP_W-1:0]      step_count = '0;
	logic                   direction  = 1'b0;
	logic signed [POS_W-1:0] target    = '0;
	logic                   empty;
	logic                   pop        = 1'b0;
	logic [MAX_AXES-1:0]    step_pins;
	logic [MAX_AXES-1:0]    dir_pins;
	logic [MAX_AXES-1:0]    enable_pins_n;
	logic                   rejected;
	logic                   homing_done;
	logic signed [POS_W-1:0] position;
	logic [STEP_W-1:0]      steps_remaining;
	logic [STEP_W-1:0]      travel_length;

	// Commands waiting to be driven, and the result beats still owed by the unit.
	motion_cmd_t cmd_backlog [$];
	res_t        status_due [$];

	// Percentage of cycles in which the sender and the receiver hold back.
	int send_idle_pct = 33;
	int take_idle_pct = 60;
	int faults        = 0;

	// Predicted state of each axis, plus the period registers as last written.
	logic [PERIOD_W-1:0] period_cfg  [AXES];
	logic                drv_on      [AXES];
	logic                run_fwd     [AXES];
	logic [STEP_W-1:0]   steps_todo  [AXES];
	logic [PERIOD_W-1:0] tick_acc    [AXES];
	logic [POS_W-1:0]    pos_now     [AXES];
	logic [STEP_W-1:0]   travel_seen [AXES];
	logic                homing_on   [AXES];
	logic                step_lvl    [AXES];
	logic                dir_lvl     [AXES];
	logic                enab_n      [AXES];

	multi_axis_stepper_pulse_controller_unit u_top (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_valid       (cfg_valid),
		.cfg_ready       (cfg_ready),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.push            (push),
		.full            (full),
		.op              (op),
		.axis            (axis),
		.step_count      (step_count),
		.direction       (direction),
		.target          (target),
		.empty           (empty),
		.pop             (pop),
		.step_pins       (step_pins),
		.dir_pins        (dir_pins),
		.enable_pins_n   (enable_pins_n),
		.rejected        (rejected),
		.homing_done     (homing_done),
		.position        (position),
		.steps_remaining (steps_remaining),
		.travel_length   (travel_length)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// ------------------------------------------------------------------------
	// Prediction of the axes.
	// ------------------------------------------------------------------------

	// Starting a move only takes effect on an enabled axis. The step pin is
	// raised straight away and the direction pin follows the requested way.
	function automatic bit begin_move(int a, logic [STEP_W-1:0] n, logic fwd);
		if (!drv_on[a])
			return 1'b0;
		steps_todo[a] = n;
		run_fwd[a]    = fwd;
		dir_lvl[a]    = fwd;
		step_lvl[a]   = 1'b1;
		return 1'b1;
	endfunction

	// One timer tick on one axis. The pin stays high for the first half of the
	// period; the step itself is taken once the count reaches the period, which
	// also covers a period that was lowered under a count already running and
	// a period of zero, where every tick steps.
	function automatic void advance_axis(int a);
		if (drv_on[a] && steps_todo[a] != '0) begin
			tick_acc[a] = tick_acc[a] + 16'd1;
			step_lvl[a] = (2 * int'(tick_acc[a])) <= int'(period_cfg[a]);
			if (tick_acc[a] >= period_cfg[a]) begin
				tick_acc[a]   = '0;
				steps_todo[a] = steps_todo[a] - 1'b1;
				pos_now[a]    = run_fwd[a] ? pos_now[a] + 1 : pos_now[a] - 1;
			end
		end
	endfunction

	// Applies one command beat to the predicted state and returns the result
	// beat that the unit must produce for it.
	function automatic res_t apply_command(motion_cmd_t c);
		res_t   r;
		bit     ok;
		bit     rej;
		longint want;
		longint here;
		longint gap;
		longint mag;
		logic [STEP_W-1:0] n;
		ok  = c.axis < AXES;
		rej = 1'b0;
		case (c.op)
			OP_TICK: begin
				for (int a = 0; a < AXES; a++)
					advance_axis(a);
			end
			OP_ENABLE, OP_DISABLE: begin
				for (int a = 0; a < AXES; a++) begin
					drv_on[a]     = (c.op == OP_ENABLE);
					steps_todo[a] = '0;
					tick_acc[a]   = '0;
					enab_n[a]     = (c.op != OP_ENABLE);
				end
			end
			OP_STOP: begin
				for (int a = 0; a < AXES; a++)
					steps_todo[a] = '0;
			end
			OP_MOVE_REL: begin
				if (ok && !begin_move(int'(c.axis), c.step_count, c.direction))
					rej = 1'b1;
			end
			OP_MOVE_ABS: begin
				if (ok) begin
					// Signed distance, saturated to the step counter; zero or
					// less counts as a move backwards.
					want = longint'(signed'(c.target));
					here = longint'(signed'(pos_now[c.axis]));
					gap  = want - here;
					mag  = (gap < 0) ? -gap : gap;
					n    = (mag > longint'(STEP_MAX)) ? STEP_MAX : mag[STEP_W-1:0];
					if (!begin_move(int'(c.axis), n, gap > 0))
						rej = 1'b1;
				end
			end
			OP_HOME: begin
				// Homing is marked even on disabled axes.
				for (int a = 0; a < AXES; a++) begin
					homing_on[a] = 1'b1;
					if (!begin_move(a, STEP_MAX, 1'b1))
						rej = 1'b1;
				end
			end
			OP_START_LIMIT: begin
				if (ok && homing_on[c.axis]) begin
					run_fwd[c.axis] = 1'b0;
					if (!begin_move(int'(c.axis), STEP_MAX, 1'b0))
						rej = 1'b1;
				end
			end
			OP_END_LIMIT: begin
				if (ok && homing_on[c.axis]) begin
					travel_seen[c.axis] = STEP_MAX - steps_todo[c.axis];
					pos_now[c.axis]     = '0;
					steps_todo[c.axis]  = '0;
					homing_on[c.axis]   = 1'b0;
				end
			end
			default: ;
		endcase

		r = '0;
		r.homing_done = 1'b1;
		for (int a = 0; a < AXES; a++) begin
			r.step_pins[a]     = step_lvl[a];
			r.dir_pins[a]      = dir_lvl[a];
			r.enable_pins_n[a] = enab_n[a];
			if (homing_on[a])
				r.homing_done = 1'b0;
		end
		r.rejected = rej;
		if (ok) begin
			r.position        = pos_now[c.axis];
			r.steps_remaining = steps_todo[c.axis];
			r.travel_length   = travel_seen[c.axis];
		end
		return r;
	endfunction

	// ------------------------------------------------------------------------
	// Command driver: presents the oldest backlog entry and holds it while
	// full is high. The prediction is made at the edge where the beat is taken.
	// ------------------------------------------------------------------------
	always @(posedge clk) begin : command_driver
		logic go;
		if (arst_n) begin
			if (push && !full) begin
				status_due.push_back(apply_command(cmd_backlog[0]));
				void'(cmd_backlog.pop_front());
			end
			if (!(push && full)) begin
				go = cmd_backlog.size() != 0 && $urandom_range(0, 99) >= send_idle_pct;
				push <= go;
				if (go) begin
					op         <= cmd_backlog[0].op;
					axis       <= cmd_backlog[0].axis;
					step_count <= cmd_backlog[0].step_count;
					direction  <= cmd_backlog[0].direction;
					target     <= cmd_backlog[0].target;
				end
			end
		end
	end

	// ------------------------------------------------------------------------
	// Result monitor: every beat taken off the result side is compared field by
	// field with the oldest prediction still waiting.
	// ------------------------------------------------------------------------
	task automatic compare_field(string name, logic [POS_W-1:0] want, logic [POS_W-1:0] got);
		if (got !== want) begin
			$display("%0t: %s expected 0x%0h, got 0x%0h", $time, name, want, got);
			faults++;
		end
	endtask

	always @(posedge clk) begin : result_monitor
		res_t want;
		if (!arst_n) begin
			pop <= 1'b0;
		end else begin
			if (pop && !empty) begin
				if (status_due.size() == 0) begin
					$display("%0t: result beat with nothing expected, position 0x%0h",
						$time, position);
					faults++;
				end else begin
					want = status_due.pop_front();
					compare_field("step_pins", POS_W'(want.step_pins), POS_W'(step_pins));
					compare_field("dir_pins", POS_W'(want.dir_pins), POS_W'(dir_pins));
					compare_field("enable_pins_n", POS_W'(want.enable_pins_n),
						POS_W'(enable_pins_n));
					compare_field("rejected", POS_W'(want.rejected), POS_W'(rejected));
					compare_field("homing_done", POS_W'(want.homing_done),
						POS_W'(homing_done));
					compare_field("position", want.position, position);
					compare_field("steps_remaining", POS_W'(want.steps_remaining),
						POS_W'(steps_remaining));
					compare_field("travel_length", POS_W'(want.travel_length),
						POS_W'(travel_length));
				end
			end
			pop <= ($urandom_range(0, 99) >= take_idle_pct);
		end
	end

	// ------------------------------------------------------------------------
	// Stimulus helpers.
	// ------------------------------------------------------------------------
	function automatic motion_cmd_t make_cmd(logic [OP_W-1:0] o, logic [AXIS_W-1:0] a,
		logic [STEP_W-1:0] n, logic fwd, logic [POS_W-1:0] tgt);
		motion_cmd_t c;
		c.op         = o;
		c.axis       = a;
		c.step_count = n;
		c.direction  = fwd;
		c.target     = tgt;
		return c;
	endfunction

	// A random command. Ticks dominate so that moves actually run to the end,
	// most move lengths are kept short and most targets are kept near zero;
	// the unused fields carry random bits throughout.
	function automatic motion_cmd_t random_cmd();
		motion_cmd_t c;
		int roll;
		int shape;
		c.axis       = ($urandom_range(0, 9) == 0) ? '1 : AXIS_W'($urandom_range(0, AXES - 1));
		c.step_count = STEP_W'($urandom);
		c.direction  = 1'($urandom_range(0, 1));
		c.target     = $urandom;
		roll         = $urandom_range(0, 99);
		shape        = $urandom_range(0, 9);
		if (roll < 55) begin
			c.op = OP_TICK;
		end else if (roll < 66) begin
			c.op = OP_MOVE_REL;
			if (shape < 6)
				c.step_count = STEP_W'($urandom_range(0, 12));
			else if (shape < 9)
				c.step_count = STEP_W'($urandom_range(0, 2000));
		end else if (roll < 74) begin
			c.op = OP_MOVE_ABS;
			if (shape < 6)
				c.target = POS_W'($urandom_range(0, 60) - 30);
			else if (shape == 9)
				c.target = $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
		end else if (roll < 78) begin
			c.op = OP_ENABLE;
		end else if (roll < 80) begin
			c.op = OP_DISABLE;
		end else if (roll < 83) begin
			c.op = OP_STOP;
		end else if (roll < 86) begin
			c.op = OP_HOME;
		end else if (roll < 92) begin
			c.op = OP_START_LIMIT;
		end else if (roll < 98) begin
			c.op = OP_END_LIMIT;
		end else begin
			c.op = OP_W'($urandom_range(OP_END_LIMIT + 1, {OP_W{1'b1}}));
		end
		return c;
	endfunction

	// A random command of the given opcode, with random bits in every field.
	function automatic motion_cmd_t noisy_cmd(logic [OP_W-1:0] o);
		return make_cmd(o, AXIS_W'($urandom), STEP_W'($urandom), 1'($urandom), $urandom);
	endfunction

	// A complete homing routine: home, run forwards, hit the start limits,
	// run backwards, hit the end limits. Axes are picked at random so that
	// some limits repeat and some axes are left homing.
	function automatic int queue_homing_run();
		int n;
		n = 0;
		if ($urandom_range(0, 9) < 7) begin
			cmd_backlog.push_back(noisy_cmd(OP_ENABLE));
			n++;
		end
		cmd_backlog.push_back(noisy_cmd(OP_HOME));
		n++;
		for (int k = 0; k < 2; k++) begin
			repeat ($urandom_range(0, 8)) begin
				cmd_backlog.push_back(noisy_cmd(OP_TICK));
				n++;
			end
			repeat (AXES) begin
				cmd_backlog.push_back(make_cmd(k == 0 ? OP_START_LIMIT : OP_END_LIMIT,
					AXIS_W'($urandom_range(0, AXES - 1)), STEP_W'($urandom),
					1'($urandom), $urandom));
				n++;
			end
		end
		return n;
	endfunction

	task automatic queue_random(int count);
		int added;
		added = 0;
		while (added < count) begin
			if ($urandom_range(0, 99) < 4) begin
				added += queue_homing_run();
			end else begin
				cmd_backlog.push_back(random_cmd());
				added++;
			end
		end
	endtask

	// Waits until every queued command has gone in and every result has come
	// out, then lets the pipeline settle.
	task automatic drain();
		while (cmd_backlog.size() != 0 || push || status_due.size() != 0)
			@(negedge clk);
		repeat (4) @(posedge clk);
	endtask

	// Writes one period register; the prediction takes the new value once the
	// beat has been accepted.
	task automatic write_period(logic [CFG_IDX_W-1:0] idx, logic [PERIOD_W-1:0] ticks);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= ticks;
		do
			@(posedge clk);
		while (!cfg_ready);
		cfg_valid <= 1'b0;
		period_cfg[idx] = ticks;
	endtask

	// Watchdog: ends the run as failed once the cycle limit is reached.
	initial begin : watchdog
		int cycles;
		cycles = 0;
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("multi_axis_stepper_pulse_controller_unit verification failed");
		$finish;
	end

	// ------------------------------------------------------------------------
	// Main sequence: reset, a directed pass at the default periods, then
	// random phases over a range of period settings. The receiver idles more
	// in the first part, the sender in the second, neither in the last.
	// ------------------------------------------------------------------------
	initial begin : stimulus
		for (int a = 0; a < AXES; a++) begin
			period_cfg[a]  = PERIOD_RESET;
			drv_on[a]      = 1'b0;
			run_fwd[a]     = 1'b0;
			steps_todo[a]  = '0;
			tick_acc[a]    = '0;
			pos_now[a]     = '0;
			travel_seen[a] = '0;
			homing_on[a]   = 1'b0;
			step_lvl[a]    = 1'b0;
			dir_lvl[a]     = 1'b0;
			enab_n[a]      = 1'b1;
		end
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		// Directed pass. Starts with everything disabled, so the first move is
		// refused; an unused opcode and an out-of-range axis change nothing.
		cmd_backlog.push_back(make_cmd(OP_TICK, '0, '0, 1'b0, '0));
		cmd_backlog.push_back(make_cmd(OP_MOVE_REL, 2'd0, 31'd5, 1'b1, '0));
		cmd_backlog.push_back(make_cmd({OP_W{1'b1}}, '1, STEP_MAX, 1'b1, '1));
		cmd_backlog.push_back(make_cmd(OP_ENABLE, 2'd1, '0, 1'b0, '0));
		cmd_backlog.push_back(make_cmd(OP_MOVE_REL, 2'd0, 31'd3, 1'b1, '0));
		cmd_backlog.push_back(make_cmd(OP_MOVE_REL, '1, STEP_MAX, 1'b1, '1));
		// Absolute moves to the far ends; the negative one saturates.
		cmd_backlog.push_back(make_cmd(OP_MOVE_ABS, 2'd1, '0, 1'b0, 32'h7FFF_FFFF));
		cmd_backlog.push_back(make_cmd(OP_MOVE_ABS, 2'd2, '0, 1'b1, 32'h8000_0000));
		// Target equal to the position: zero steps, direction backwards.
		cmd_backlog.push_back(make_cmd(OP_MOVE_ABS, 2'd1, '0, 1'b1, '0));
		// Limit events without homing are ignored.
		cmd_backlog.push_back(make_cmd(OP_START_LIMIT, 2'd0, '0, 1'b0, '0));
		cmd_backlog.push_back(make_cmd(OP_END_LIMIT, 2'd1, '0, 1'b0, '0));
		cmd_backlog.push_back(make_cmd(OP_TICK, 2'd0, '0, 1'b0, '0));
		cmd_backlog.push_back(make_cmd(OP_STOP, 2'd2, '0, 1'b0, '0));
		cmd_backlog.push_back(make_cmd(OP_HOME, 2'd0, '0, 1'b0, '0));
		cmd_backlog.push_back(make_cmd(OP_START_LIMIT, 2'd0, '0, 1'b0, '0));
		cmd_backlog.push_back(make_cmd(OP_TICK, 2'd0, '0, 1'b0, '0));
		cmd_backlog.push_back(make_cmd(OP_END_LIMIT, 2'd0, '0, 1'b0, '0));
		cmd_backlog.push_back(make_cmd(OP_DISABLE, 2'd1, '0, 1'b0, '0));
		// Homing on disabled axes: refused, yet the axes are marked homing,
		// and a start limit still applies.
		cmd_backlog.push_back(make_cmd(OP_HOME, 2'd1, '0, 1'b0, '0));
		cmd_backlog.push_back(make_cmd(OP_START_LIMIT, 2'd2, '0, 1'b0, '0));
		// Re-enabling leaves homing set; end limits finish it off.
		cmd_backlog.push_back(make_cmd(OP_ENABLE, 2'd2, '0, 1'b0, '0));
		cmd_backlog.push_back(make_cmd(OP_MOVE_REL, 2'd2, '0, 1'b0, '0));
		cmd_backlog.push_back(make_cmd(OP_END_LIMIT, 2'd2, '0, 1'b0, '0));
		cmd_backlog.push_back(make_cmd(OP_END_LIMIT, 2'd1, '0, 1'b0, '0));
		cmd_backlog.push_back(make_cmd(OP_END_LIMIT, '1, '0, 1'b0, '0));
		queue_random(150);
		drain();

		// Fastest periods and the slowest one.
		write_period(REG_PERIOD_AXIS0, 16'd1);
		write_period(REG_PERIOD_AXIS1, 16'd2);
		write_period(REG_PERIOD_AXIS2, 16'hFFFF);
		queue_random(250);
		drain();

		// Now the sender is the slow side. A period of zero steps on every
		// tick, and axis 2 drops from the slowest period in mid-count.
		send_idle_pct = 60;
		take_idle_pct = 33;
		write_period(REG_PERIOD_AXIS0, 16'd0);
		write_period(REG_PERIOD_AXIS1, 16'd3);
		write_period(REG_PERIOD_AXIS2, 16'd1);
		queue_random(250);
		drain();

		write_period(REG_PERIOD_AXIS0, PERIOD_W'($urandom_range(1, 40)));
		write_period(REG_PERIOD_AXIS1, PERIOD_W'($urandom_range(1, 40)));
		write_period(REG_PERIOD_AXIS2, PERIOD_W'($urandom_range(1, 40)));
		queue_random(250);
		drain();

		// Back-to-back beats on both sides for the last stretch.
		send_idle_pct = 0;
		take_idle_pct = 0;
		write_period(REG_PERIOD_AXIS0, 16'd2);
		write_period(REG_PERIOD_AXIS1, 16'hFFFF);
		write_period(REG_PERIOD_AXIS2, 16'd1);
		queue_random(300);
		drain();
		repeat (10) @(posedge clk);

		if (faults == 0)
			$display("multi_axis_stepper_pulse_controller_unit verification clean");
		else
			$display("multi_axis_stepper_pulse_controller_unit verification failed");
		$finish;
	end

endmodule
